>>> hw/rtl/pdm_pkg.sv
// ----------------------------------------------------------------------------
// Pairwise distance matrix package
// Shared types and constants for the distance matrix block.
// ----------------------------------------------------------------------------
package pdm_pkg;

   // Configuration register indexes.
   localparam logic [0:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [0:0] CSR_DIMS_IN_USE = 1'b1;

   localparam int NUM_FIELDS = 4;
   localparam int DIST_BITS = 17;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STORE,
      ST_SWEEP
   } seq_state_type;

endpackage

>>> hw/rtl/pdm_if.sv
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface pdm_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/pdm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One stage of a pipelined restoring square root; two radicand bits a stage.
// Carries the row/column tags alongside the partial result.
// ----------------------------------------------------------------------------
module pdm_sqrt_cell #(
   parameter int XW = 36,
   parameter int RW = 18,
   parameter int TW = 14,
   parameter int STAGE = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  logic [XW-1:0] in_rem,
   input  logic [RW-1:0] in_res,
   input  logic [TW-1:0] in_tag,
   output logic          out_vld,
   output logic [XW-1:0] out_rem,
   output logic [RW-1:0] out_res,
   output logic [TW-1:0] out_tag
);
   localparam int SH = 2 * (RW - 1 - STAGE);

   logic          vld_ff;
   logic [XW-1:0] rem_ff, rem_in;
   logic [RW-1:0] res_ff, res_in;
   logic [TW-1:0] tag_ff;
   logic [XW:0]   trial;

   // Try setting result bit b: compare 2*res*2^b + 2^(2b) against the remainder.
   always_comb begin
      trial = ({1'b0, {(XW-RW){1'b0}}, in_res} << (RW - STAGE))
            | ((XW+1)'(1) << SH);
      if ({1'b0, in_rem} >= trial) begin
         rem_in = in_rem - trial[XW-1:0];
         res_in = in_res | (RW'(1) << (RW - 1 - STAGE));
      end else begin
         rem_in = in_rem;
         res_in = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      tag_ff <= in_tag;
   end

   assign out_vld = vld_ff;
   assign out_rem = rem_ff;
   assign out_res = res_ff;
   assign out_tag = tag_ff;
endmodule

>>> hw/rtl/pdm_dist_unit.sv
// ----------------------------------------------------------------------------
// Squared distance unit
// Registered differences, registered squares, registered sum.
// ----------------------------------------------------------------------------
module pdm_dist_unit #(
   parameter int MAX_DIMS = 4,
   parameter int COORD_BITS = 16,
   parameter int TW = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_vld,
   input  logic [MAX_DIMS-1:0][COORD_BITS-1:0] pa,
   input  logic [MAX_DIMS-1:0][COORD_BITS-1:0] pb,
   input  logic [MAX_DIMS-1:0]               dmask,
   input  logic [TW-1:0]                     in_tag,
   output logic                              out_vld,
   output logic [2*COORD_BITS+3:0]           out_sum,
   output logic [TW-1:0]                     out_tag
);
   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * COORD_BITS + 4;

   logic [MAX_DIMS-1:0][DW-1:0]   mag_ff;
   logic [MAX_DIMS-1:0][2*DW-1:0] sq_ff;
   logic [SW-1:0]                 sum_ff, sum_in;
   logic [2:0]                    vld_ff;
   logic [2:0][TW-1:0]            tag_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         // The difference of two coordinates is formed two bits wider than a coordinate.
         logic signed [DW:0] df;
         df = $signed({{2{pa[k][COORD_BITS-1]}}, pa[k]})
            - $signed({{2{pb[k][COORD_BITS-1]}}, pb[k]});
         mag_ff[k] <= !dmask[k] ? '0 : (df[DW] ? DW'(-df) : DW'(df));
         sq_ff[k]  <= mag_ff[k] * mag_ff[k];
      end
      sum_ff <= sum_in;
      tag_ff <= {tag_ff[1:0], in_tag};
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
   end

   // Adder over the registered squares.
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         sum_in = sum_in + SW'(sq_ff[k]);
      end
   end

   assign out_vld = vld_ff[2];
   assign out_sum = sum_ff;
   assign out_tag = tag_ff[2];
endmodule

>>> hw/rtl/pairwise_distance_matrix.sv
// ----------------------------------------------------------------------------
// Pairwise distance matrix
// One point is in flight at a time: a new point is taken only once every
// result of the last one has been taken, and its row r sweeps columns 0..r.
// The sweep reads the point memory once per cycle and pauses while 32
// results are outstanding; a chain of square root cells then yields one
// result per cycle. Reset clears the slot counter and loads point_count 64
// and dims_in_use 2; the point memory is not cleared.
// ----------------------------------------------------------------------------
module pairwise_distance_matrix
   import pdm_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int MAX_DIMS = 4,
   parameter int COORD_BITS = 16
) (
   input  logic  clock,
   input  logic  reset,
   pdm_if.sink   req,
   pdm_if.source rsp,
   pdm_if.sink   csr
);
   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int TW  = 2 * AW + 1;
   localparam int SW  = 2 * COORD_BITS + 4;
   localparam int RW  = SW / 2;
   localparam int ND  = (MAX_DIMS < NUM_FIELDS) ? MAX_DIMS : NUM_FIELDS;
   localparam int FIFO_DEPTH = 32;
   localparam int FAW = 5;

   // req.data: {coord_d, coord_c, coord_b, coord_a}; rsp.data:
   // {last_of_row, distance, col_index, row_index}; csr.data: {index, value}.
   logic [6:0]  point_count_ff;
   logic [2:0]  dims_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 7'd64;
         dims_in_use_ff <= 3'd2;
      end else if (csr.valid && csr.ready) begin
         case (csr.data[7])
            CSR_POINT_COUNT: point_count_ff <= csr.data[6:0];
            CSR_DIMS_IN_USE: dims_in_use_ff <= csr.data[2:0];
            default: ;
         endcase
      end
   end
   assign csr.ready = 1'b1;

   // Effective counts.
   logic [CW-1:0] n_eff;
   logic [3:0]    d_eff;
   always_comb begin
      if (point_count_ff == 7'd0) begin
         n_eff = CW'(1);
      end else if (32'(point_count_ff) > MAX_POINTS) begin
         n_eff = CW'(MAX_POINTS);
      end else begin
         n_eff = CW'(point_count_ff);
      end
      if (dims_in_use_ff == 3'd0) begin
         d_eff = 4'd1;
      end else if (32'(dims_in_use_ff) > ND) begin
         d_eff = 4'(ND);
      end else begin
         d_eff = 4'(dims_in_use_ff);
      end
   end

   // Point memory.
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] mem [MAX_POINTS];
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] rd_ff, new_ff, wr_pt;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   seq_state_type state_ff, state_in;
   logic [AW-1:0] next_slot_ff, next_slot_in, row_ff, row_in, col_ff, col_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic [FAW:0]  outst_ff, outst_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rdcol_ff;
   logic          rdlast_ff;

   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         wr_pt[k] = (k < NUM_FIELDS) ? req.data[16*k +: COORD_BITS] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[row_in] <= wr_pt;
         new_ff <= wr_pt;
      end
      rd_ff <= mem[rd_addr];
      rdcol_ff <= col_ff;
      rdlast_ff <= (col_ff == row_ff);
   end

   // Sequencer: store the point, then sweep columns 0..row.
   logic [AW:0] row_next;
   always_comb begin
      state_in = state_ff;
      next_slot_in = next_slot_ff;
      row_in = row_ff;
      col_in = col_ff;
      rd_vld_in = 1'b0;
      mem_we = 1'b0;
      req.ready = 1'b0;
      rd_addr = col_ff;
      row_next = '0;
      pend_in = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            req.ready = (pend_ff == '0);
            if (CW'(next_slot_ff) >= n_eff) begin
               row_in = '0;
            end else begin
               row_in = next_slot_ff;
            end
            if (req.valid && req.ready) begin
               mem_we = 1'b1;
               row_next = {1'b0, row_in} + 1'b1;
               next_slot_in = (CW'(row_next) >= n_eff) ? '0 : row_next[AW-1:0];
               col_in = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // Issue a column only while the result FIFO holds an entry for it.
            if (outst_ff < (FAW+1)'(FIFO_DEPTH)) begin
               rd_vld_in = 1'b1;
               if (col_ff == row_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE && req.valid && req.ready) begin
         pend_in = CW'({1'b0, row_in}) + 1'b1;
      end else if (rsp.valid && rsp.ready) begin
         pend_in = pend_ff - 1'b1;
      end
      outst_in = outst_ff + (FAW+1)'(rd_vld_in) - (FAW+1)'(rsp.valid && rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_slot_ff <= '0;
         rd_vld_ff <= 1'b0;
         pend_ff <= '0;
         outst_ff <= '0;
      end else begin
         state_ff <= state_in;
         next_slot_ff <= next_slot_in;
         rd_vld_ff <= rd_vld_in;
         pend_ff <= pend_in;
         outst_ff <= outst_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
   end

   // Dimension mask.
   logic [MAX_DIMS-1:0] dmask;
   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         dmask[k] = (k < 32'(d_eff));
      end
   end

   logic          sq_vld;
   logic [SW-1:0] sq_sum;
   logic [TW-1:0] sq_tag;

   pdm_dist_unit #(.MAX_DIMS(MAX_DIMS), .COORD_BITS(COORD_BITS), .TW(TW)) u_dist (
      .clock(clock), .reset(reset), .in_vld(rd_vld_ff), .pa(new_ff), .pb(rd_ff),
      .dmask(dmask), .in_tag({rdlast_ff, rdcol_ff, row_ff}),
      .out_vld(sq_vld), .out_sum(sq_sum), .out_tag(sq_tag)
   );

   // Chain of square root cells.
   logic [RW:0]          c_vld;
   logic [RW:0][SW-1:0]  c_rem;
   logic [RW:0][RW-1:0]  c_res;
   logic [RW:0][TW-1:0]  c_tag;
   assign c_vld[0] = sq_vld;
   assign c_rem[0] = sq_sum;
   assign c_res[0] = '0;
   assign c_tag[0] = sq_tag;

   for (genvar g = 0; g < RW; g++) begin : g_sqrt
      pdm_sqrt_cell #(.XW(SW), .RW(RW), .TW(TW), .STAGE(g)) u_cell (
         .clock(clock), .reset(reset),
         .in_vld(c_vld[g]), .in_rem(c_rem[g]), .in_res(c_res[g]), .in_tag(c_tag[g]),
         .out_vld(c_vld[g+1]), .out_rem(c_rem[g+1]), .out_res(c_res[g+1]),
         .out_tag(c_tag[g+1])
      );
   end

   // Result FIFO; outst_ff keeps its occupancy within its depth.
   logic [TW+DIST_BITS-1:0] fifo [FIFO_DEPTH];
   logic [FAW-1:0] wp_ff, rp_ff;
   logic [FAW:0]   cnt_ff;
   logic [DIST_BITS-1:0] dist_sat;
   logic [TW-1:0] out_tag;
   logic [TW+DIST_BITS-1:0] head;

   assign dist_sat = (c_res[RW] > RW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(c_res[RW]);

   always_ff @(posedge clock) begin
      if (c_vld[RW]) begin
         fifo[wp_ff] <= {c_tag[RW], dist_sat};
      end
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (c_vld[RW]) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (rsp.valid && rsp.ready) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (FAW+1)'(c_vld[RW]) - (FAW+1)'(rsp.valid && rsp.ready);
      end
   end

   assign head = fifo[rp_ff];
   assign out_tag = head[TW+DIST_BITS-1:DIST_BITS];
   assign rsp.valid = (cnt_ff != '0);
   assign rsp.data = {out_tag[TW-1], head[DIST_BITS-1:0],
                      6'(out_tag[2*AW-1:AW]), 6'(out_tag[AW-1:0])};

   // Checks on the sequencer and the result FIFO.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !req.ready) else $error("accept during sweep");
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (col_ff <= row_ff)) else $error("column past row");
   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (FAW+1)'(FIFO_DEPTH)) else $error("result fifo overflow");
   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= (FAW+1)'(FIFO_DEPTH)) else $error("too many results outstanding");
endmodule
